FILE: hdl/arpc_pkg.sv
// Shared types and constants for the ARP cache resolver.
// Transaction payload structs, entry layout, register and FSM codes.
// No dependencies.
`default_nettype none

package arpc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 5;
  localparam logic [31:0] MAX_AGE_RESET   = 32'd43200;

  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_LEARN   = 1'b1;

  typedef enum logic [1:0] {
    REG_OWN_IP      = 2'd0,
    REG_SUBNET_MASK = 2'd1,
    REG_GATEWAY_IP  = 2'd2,
    REG_MAX_AGE     = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] resolved_mac;
    logic [31:0] request_ip;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/arpc_table.sv
// Entry store of the ARP cache: one-port-write, one-port-read synchronous memory
// plus per-entry valid flags. Invalid entries read as all zero.
// Depends on arpc_pkg.
`default_nettype none

module arpc_table
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT,
  parameter int unsigned IDX_W   = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic             clr_en,
  input  wire logic [IDX_W-1:0] clr_addr,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  entry_t             rd_q;
  logic               rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // valid flags stand in for the all-zero reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid[clr_addr] <= 1'b0;
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

FILE: hdl/arp_cache_resolver.sv
// ARP cache resolver top level: APB register file, walk sequencer, result register.
// Depends on arpc_pkg and arpc_table.
`default_nettype none

// Usage
// - Command channel: cmd is taken at a rising edge with start high and busy low.
//   cmd.operation selects learn (store ip/mac/now at the round-robin slot) or
//   resolve (look up the on-link target, or gateway_ip when off-link).
// - Result channel: result_valid pulses for one cycle with the result fields.
//   The receiver cannot stall; every transaction yields exactly one result.
// - Latency: a learn completes at its accept edge; its result shows in the next
//   cycle and busy never rises, so learns can issue every cycle.
// - A resolve walks the table one entry per cycle from entry 0, reading entry
//   k+1 from the memory while entry k is checked. Busy stays high for the walk,
//   up to a hit or, on a miss, through the last entry. The result appears in the
//   cycle after the last checked entry, and a new command may be taken then.
//   Throughput is bound by that single memory read port.
// - Entries older than max_age (wrapping now_time - stamp) are dropped as the
//   walk passes them; entries beyond a hit are left untouched.
// - Reset: all entries read as zero (valid flags cleared at once, no sweep), fill
//   slot 0, max_age 43200, others 0. Users change registers only idle; unenforced.
module arp_cache_resolver
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command transaction
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    cmd,
  // result transaction
  output logic             result_valid,
  output out_item_t        result,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // ---- configuration registers ----
  logic [31:0] own_ip;
  logic [31:0] subnet_mask;
  logic [31:0] gateway_ip;
  logic [31:0] max_age;
  reg_idx_t    reg_sel;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip      <= '0;
      subnet_mask <= '0;
      gateway_ip  <= '0;
      max_age     <= MAX_AGE_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_OWN_IP:      own_ip      <= pwdata;
        REG_SUBNET_MASK: subnet_mask <= pwdata;
        REG_GATEWAY_IP:  gateway_ip  <= pwdata;
        REG_MAX_AGE:     max_age     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OWN_IP:      prdata = own_ip;
      REG_SUBNET_MASK: prdata = subnet_mask;
      REG_GATEWAY_IP:  prdata = gateway_ip;
      REG_MAX_AGE:     prdata = max_age;
      default:         prdata = '0;
    endcase
  end

  // ---- sequencer state ----
  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] walk_idx;
  logic [IDX_W-1:0] fill_index;
  logic [31:0]      target;
  logic [31:0]      walk_now;

  logic accept;
  logic accept_learn;
  logic accept_resolve;
  logic [31:0] target_in;

  assign accept         = start && !busy;
  assign accept_learn   = accept && (cmd.operation == OP_LEARN);
  assign accept_resolve = accept && (cmd.operation == OP_RESOLVE);

  // on-link test: masked difference from own address must be zero
  assign target_in = (((cmd.ip_address ^ own_ip) & subnet_mask) == '0) ?
                     cmd.ip_address : gateway_ip;

  // ---- entry store ----
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic [IDX_W-1:0] rd_addr;
  logic             clr_en;

  assign wr_entry = '{ip: cmd.ip_address, mac: cmd.mac_address, stamp: cmd.now_time};

  arpc_table #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept_learn),
    .wr_addr  (fill_index),
    .wr_data  (wr_entry),
    .clr_en   (clr_en),
    .clr_addr (walk_idx),
    .rd_addr  (rd_addr),
    .rd_data  (rd_entry)
  );

  // ---- entry check (entry walk_idx is on rd_entry while walking) ----
  logic [31:0] age;
  logic        expired;
  logic [31:0] eff_ip;
  logic [47:0] eff_mac;
  logic        match;
  logic        last;

  assign age     = walk_now - rd_entry.stamp;
  assign expired = age > max_age;
  assign eff_ip  = expired ? '0 : rd_entry.ip;
  assign eff_mac = expired ? '0 : rd_entry.mac;
  assign match   = (eff_ip == target);
  assign last    = (walk_idx == LAST_IDX);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_resolve) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (match || last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy    = 1'b0;
    clr_en  = 1'b0;
    rd_addr = '0;
    case (state)
      ST_IDLE: begin
        rd_addr = '0;  // entry 0 prefetched for a resolve taken now
      end
      ST_WALK: begin
        busy    = 1'b1;
        clr_en  = expired;
        rd_addr = last ? '0 : walk_idx + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      walk_idx   <= '0;
      fill_index <= '0;
    end else begin
      state <= state_next;
      if (accept_resolve) begin
        walk_idx <= '0;
      end else if (state == ST_WALK) begin
        walk_idx <= walk_idx + 1'b1;
      end
      if (accept_learn) begin
        fill_index <= (fill_index == LAST_IDX) ? '0 : fill_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_resolve) begin
      target   <= target_in;
      walk_now <= cmd.now_time;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= accept_learn || ((state == ST_WALK) && (match || last));
    end
  end

  always_ff @(posedge clk) begin
    if (accept_learn) begin
      result <= '0;
    end else if (state == ST_WALK) begin
      if (match) begin
        result <= '{hit: 1'b1, resolved_mac: eff_mac, request_ip: '0};
      end else begin
        result <= '{hit: 1'b0, resolved_mac: '0, request_ip: target};
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/arpc_checker.sv
// Port-level checks for the ARP cache resolver, bound to the top level.
// Depends on arpc_pkg and arp_cache_resolver.
`default_nettype none

module arpc_checker
  import arpc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  cmd,
  input wire logic      result_valid,
  input wire out_item_t result
);

  // learn completes at once with an all-zero result
  a_learn_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.operation == OP_LEARN |=>
      result_valid && !result.hit && result.resolved_mac == '0 && result.request_ip == '0)
    else $error("learn transaction did not give a zero result next cycle");

  // a resolve always walks at least one entry
  a_resolve_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.operation == OP_RESOLVE |=> busy && !result_valid)
    else $error("resolve transaction did not occupy the block");

  a_hit_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit |-> result.request_ip == '0)
    else $error("hit result carries a request address");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |-> result.resolved_mac == '0)
    else $error("miss result carries a MAC");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("block not quiet after reset");

endmodule

bind arp_cache_resolver arpc_checker u_arpc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire

FILE: sim/tb_arp_cache_resolver.sv
// Self-checking testbench for arp_cache_resolver: directed and random command traffic.
// It predicts each result from its own copy of the ARP table and registers.
// Depends on arpc_pkg and the arp_cache_resolver RTL.

module tb_arp_cache_resolver;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  // Tracks the cache contents and registers, and holds the replies still owed
  // by the block, oldest first.
  class arp_table_tracker;
    logic [31:0] own_ip;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_ip;
    logic [31:0] max_age;
    logic [31:0] ip_tab[ENTRIES_DEFAULT];
    logic [47:0] mac_tab[ENTRIES_DEFAULT];
    logic [31:0] stamp_tab[ENTRIES_DEFAULT];
    int unsigned fill_slot;
    out_item_t   pending_replies[$];
    int unsigned errors;

    function new();
      own_ip      = '0;
      subnet_mask = '0;
      gateway_ip  = '0;
      max_age     = MAX_AGE_RESET;
      for (int k = 0; k < ENTRIES_DEFAULT; k++) begin
        ip_tab[k]    = '0;
        mac_tab[k]   = '0;
        stamp_tab[k] = '0;
      end
      fill_slot = 0;
      errors    = 0;
    endfunction

    function void flag(string msg);
      if (errors < 10) $display("%s", msg);
      errors++;
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_OWN_IP:      own_ip      = v;
        REG_SUBNET_MASK: subnet_mask = v;
        REG_GATEWAY_IP:  gateway_ip  = v;
        REG_MAX_AGE:     max_age     = v;
        default: ;
      endcase
    endfunction

    // Applies one accepted command to the table and queues the reply it owes.
    function void note_command(in_item_t c);
      out_item_t   r;
      logic [31:0] target;
      logic [31:0] age;
      bit          found;
      r = '0;
      if (c.operation == OP_LEARN) begin
        if (fill_slot >= ENTRIES_DEFAULT) fill_slot = 0;
        ip_tab[fill_slot]    = c.ip_address;
        mac_tab[fill_slot]   = c.mac_address;
        stamp_tab[fill_slot] = c.now_time;
        fill_slot = (fill_slot + 1 >= ENTRIES_DEFAULT) ? 0 : fill_slot + 1;
      end else begin
        // on-link targets are looked up directly, everything else via the gateway
        target = (((c.ip_address ^ own_ip) & subnet_mask) == '0) ? c.ip_address : gateway_ip;
        found  = 1'b0;
        for (int k = 0; k < ENTRIES_DEFAULT; k++) begin
          if (!found) begin
            age = c.now_time - stamp_tab[k];
            if (age > max_age) begin
              ip_tab[k]    = '0;
              mac_tab[k]   = '0;
              stamp_tab[k] = '0;
            end
            if (ip_tab[k] == target) begin
              found          = 1'b1;
              r.hit          = 1'b1;
              r.resolved_mac = mac_tab[k];
            end
          end
        end
        if (!found) r.request_ip = target;
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        flag($sformatf("unexpected result: hit=%0b mac=%012h ip=%08h",
                       got.hit, got.resolved_mac, got.request_ip));
        return;
      end
      want = pending_replies.pop_front();
      if (got.hit !== want.hit || got.resolved_mac !== want.resolved_mac ||
          got.request_ip !== want.request_ip)
        flag($sformatf("result: expected hit=%0b mac=%012h ip=%08h, got hit=%0b mac=%012h ip=%08h",
                       want.hit, want.resolved_mac, want.request_ip,
                       got.hit, got.resolved_mac, got.request_ip));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    cmd;
  logic        result_valid;
  out_item_t   result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  arp_table_tracker tracker;
  int unsigned      idle_pct;

  arp_cache_resolver #(.ENTRIES(ENTRIES_DEFAULT)) dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: samples at the edge, before the block's own updates land.
  // Result first, so a reply and a new accept on one edge stay in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) tracker.check_reply(result);
      if (start && !busy) tracker.note_command(cmd);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2ms;
    $display("arp_cache_resolver: mismatch");
    $finish;
  end

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // One command transaction. An optional random idle gap comes first; start is
  // then held until the edge where busy is low.
  task automatic issue(logic op, logic [31:0] ip, logic [47:0] mac, logic [31:0] now);
    int unsigned gap;
    in_item_t    c;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    c.operation   = op;
    c.ip_address  = ip;
    c.mac_address = mac;
    c.now_time    = now;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop issuing and let every owed reply come back; the walk is then over.
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (ENTRIES_DEFAULT + 2) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic reg_write(reg_idx_t r, logic [31:0] v);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_reg(r, v);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== v)
      tracker.flag($sformatf("register %s: expected %08h, read %08h", r.name(), v, got));
  endtask

  initial begin
    logic [31:0] pool[8];
    logic [31:0] now_s;
    logic [31:0] span;
    logic [31:0] mask;
    int unsigned roll;
    int unsigned guard;

    tracker  = new();
    idle_pct = 32;
    rst     <= 1'b1;
    start   <= 1'b0;
    cmd     <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: reset settings, mask 0 so every target is on-link ----
    // zero target hits an empty entry with MAC 0
    issue(OP_RESOLVE, 32'h0000_0000, 48'h0, 32'h0000_0000);
    issue(OP_RESOLVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0000_0000);
    // fill all slots, then one more to wrap back onto slot 0
    issue(OP_LEARN, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 32'd1000);
    issue(OP_LEARN, 32'h0A00_0002, 48'h0000_0000_0001, 32'd1000);
    issue(OP_LEARN, 32'hFFFF_FFFF, 48'h8000_0000_0000, 32'd1000);
    issue(OP_LEARN, 32'hC0A8_0101, 48'h0123_4567_89AB, 32'd2000);
    issue(OP_LEARN, 32'h0A00_0003, 48'h0000_0000_0000, 32'd2000);
    issue(OP_LEARN, 32'h0A00_0004, 48'hAAAA_AAAA_AAAA, 32'd2000);
    issue(OP_RESOLVE, 32'h0A00_0004, 48'h0, 32'd3000);
    issue(OP_RESOLVE, 32'hFFFF_FFFF, 48'h0, 32'd3000);
    issue(OP_RESOLVE, 32'h0A00_0001, 48'h0, 32'd3000);
    // one past max_age for the early entries: they drop, later ones survive
    issue(OP_RESOLVE, 32'h0A00_0003, 48'h0, 32'd44201);
    // a cleared entry reads as ip 0
    issue(OP_RESOLVE, 32'h0000_0000, 48'h0, 32'd44201);
    // time counter wrap: small wrapped age keeps the entry
    issue(OP_LEARN, 32'h0A00_0005, 48'h5555_5555_5555, 32'hFFFF_FFF0);
    issue(OP_RESOLVE, 32'h0A00_0005, 48'h0, 32'h0000_0010);
    // time running backwards looks like a huge age: everything ages out
    issue(OP_RESOLVE, 32'h0A00_0005, 48'h0, 32'hFFFF_FFE0);

    // gateway path
    drain();
    reg_write(REG_OWN_IP, 32'hC0A8_0105);
    reg_write(REG_SUBNET_MASK, 32'hFFFF_FF00);
    reg_write(REG_GATEWAY_IP, 32'hC0A8_01FE);
    reg_write(REG_MAX_AGE, MAX_AGE_RESET);
    issue(OP_LEARN, 32'hC0A8_01FE, 48'h0000_0000_FEFE, 32'd100);
    issue(OP_RESOLVE, 32'h0808_0808, 48'h0, 32'd100);
    issue(OP_RESOLVE, 32'hC0A8_0177, 48'h0, 32'd100);

    // ---- random: six register settings, ~200 commands each ----
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          reg_write(REG_OWN_IP, 32'hC0A8_0105);
          reg_write(REG_SUBNET_MASK, 32'hFFFF_FF00);
          reg_write(REG_GATEWAY_IP, 32'hC0A8_01FE);
          reg_write(REG_MAX_AGE, 32'd500);
        end
        1: begin
          // all on-link, and any age at all expires an entry
          reg_write(REG_OWN_IP, $urandom);
          reg_write(REG_SUBNET_MASK, 32'h0000_0000);
          reg_write(REG_GATEWAY_IP, $urandom);
          reg_write(REG_MAX_AGE, 32'h0000_0000);
        end
        2: begin
          // host mask, entries never age out
          reg_write(REG_OWN_IP, $urandom);
          reg_write(REG_SUBNET_MASK, 32'hFFFF_FFFF);
          reg_write(REG_GATEWAY_IP, $urandom);
          reg_write(REG_MAX_AGE, 32'hFFFF_FFFF);
        end
        3: begin
          mask = 32'hFFFF_FFFF << $urandom_range(32);
          reg_write(REG_OWN_IP, $urandom);
          reg_write(REG_SUBNET_MASK, mask);
          reg_write(REG_GATEWAY_IP, $urandom);
          reg_write(REG_MAX_AGE, $urandom_range(1, 5000));
        end
        4: begin
          reg_write(REG_OWN_IP, 32'hFFFF_FFFF);
          reg_write(REG_SUBNET_MASK, 32'hFFFF_0000);
          reg_write(REG_GATEWAY_IP, 32'h0000_0000);
          reg_write(REG_MAX_AGE, MAX_AGE_RESET);
        end
        default: begin
          reg_write(REG_OWN_IP, 32'h0000_0000);
          reg_write(REG_SUBNET_MASK, 32'hFF00_0000);
          reg_write(REG_GATEWAY_IP, 32'hFFFF_FFFF);
          reg_write(REG_MAX_AGE, 32'd1000);
        end
      endcase

      // Address pool: half on-link, the gateway itself, the rest anywhere.
      for (int k = 0; k < 8; k++) begin
        if (k < 4)
          pool[k] = (tracker.own_ip & tracker.subnet_mask) | ($urandom & ~tracker.subnet_mask);
        else if (k == 4)
          pool[k] = tracker.gateway_ip;
        else
          pool[k] = $urandom;
      end

      // phase 2 starts just short of the time counter wrap
      now_s    = (phase == 2) ? 32'hFFFF_FF00 : $urandom;
      span     = (tracker.max_age > 32'd160000) ? 32'd20000 : tracker.max_age / 8 + 1;
      // phase 3 is the stretch with back-to-back commands
      idle_pct = (phase == 3) ? 0 : 32;

      for (int n = 0; n < 200; n++) begin
        // sender holds off once until the block has caught up completely
        if (phase == 1 && n == 100) drain();

        roll = $urandom_range(99);
        if (roll < 4) now_s = $urandom;
        else if (roll < 7) now_s = now_s - $urandom_range(1, 50);
        else now_s = now_s + $urandom_range(0, span);

        roll = $urandom_range(99);
        if (roll < 10)
          // noise: any operation, any address, any time
          issue(1'($urandom), $urandom, rand_mac(), $urandom);
        else if (roll < 45)
          issue(OP_LEARN, pool[$urandom_range(7)], rand_mac(), now_s);
        else if (roll < 85)
          issue(OP_RESOLVE, pool[$urandom_range(7)], rand_mac(), now_s);
        else
          issue(OP_RESOLVE, $urandom, rand_mac(), now_s);
      end
    end

    // ---- wind down ----
    start <= 1'b0;
    guard = 0;
    while (tracker.pending_replies.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (ENTRIES_DEFAULT + 4) @(posedge clk);
    if (tracker.pending_replies.size() != 0)
      tracker.flag($sformatf("%0d expected results never arrived",
                             tracker.pending_replies.size()));

    if (tracker.errors == 0) begin
      $display("arp_cache_resolver: match");
    end else begin
      $display("arp_cache_resolver: mismatch");
    end
    $finish;
  end

endmodule

FILE: arp_cache_resolver.f
hdl/arpc_pkg.sv
hdl/arpc_table.sv
hdl/arp_cache_resolver.sv
hdl/arpc_checker.sv
sim/tb_arp_cache_resolver.sv
